// ===== src/dchs_pkg.sv =====
// ----------------------------------------------------------------------------
// dchs_pkg
// Types and fixed constants shared by the depth crop histogram shader.
// ----------------------------------------------------------------------------
package dchs_pkg;

    // Width of one bin and its saturation value.
    localparam int BIN_W = 19;
    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    // The shade quotient never exceeds 256, so nine bits hold it.
    localparam int QUOT_W = 9;
    localparam int STEP_W = $clog2(QUOT_W);

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_CROP_LEFT   = 3'd0;
    localparam logic [2:0] REG_CROP_RIGHT  = 3'd1;
    localparam logic [2:0] REG_CROP_TOP    = 3'd2;
    localparam logic [2:0] REG_CROP_BOTTOM = 3'd3;
    localparam logic [2:0] REG_NEAR_LIMIT  = 3'd4;
    localparam logic [2:0] REG_FAR_LIMIT   = 3'd5;

    localparam logic [9:0]  CROP_LEFT_RST   = 10'd0;
    localparam logic [9:0]  CROP_RIGHT_RST  = 10'd639;
    localparam logic [8:0]  CROP_TOP_RST    = 9'd0;
    localparam logic [8:0]  CROP_BOTTOM_RST = 9'd479;
    localparam logic [13:0] NEAR_LIMIT_RST  = 14'd0;
    localparam logic [13:0] FAR_LIMIT_RST   = 14'd10000;

    // Request actions.
    localparam logic [1:0] ACT_CLEAR      = 2'd0;
    localparam logic [1:0] ACT_ACCUMULATE = 2'd1;
    localparam logic [1:0] ACT_FINALIZE   = 2'd2;
    localparam logic [1:0] ACT_MAP        = 2'd3;

    localparam logic [7:0] KEPT_LEVEL = 8'd255;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  column;
        logic [8:0]  row;
        logic [15:0] depth;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] primary_channel;
        logic [7:0] shade;
    } pixel_rsp_t;

endpackage

// ===== src/dchs_shade_div.sv =====
// ----------------------------------------------------------------------------
// dchs_shade_div
// Restoring divider that forms floor(256 * rest / total) one bit per cycle.
// ----------------------------------------------------------------------------
module dchs_shade_div
    import dchs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [BIN_W-1:0]  rest,
    input  logic [BIN_W-1:0]  total,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [BIN_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [BIN_W-1:0]  total_reg;
    logic [BIN_W:0]    shifted;
    logic              fits;

    // The first step compares rest itself against total (the 256 bit); rest
    // never exceeds total, so every later remainder stays below total.
    always_comb
    begin
        if (step_reg == STEP_W'(QUOT_W - 1))
        begin
            shifted = {1'b0, rem_reg};
        end
        else
        begin
            shifted = {rem_reg, 1'b0};
        end
        fits = (shifted >= {1'b0, total_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= rest;
            total_reg <= total;
            quot_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= BIN_W'(shifted - {1'b0, total_reg});
            end
            else
            begin
                rem_reg <= shifted[BIN_W-1:0];
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== src/depth_crop_histogram_shader.sv =====
// ----------------------------------------------------------------------------
// depth_crop_histogram_shader
// Depth histogram engine: clear, accumulate, finalize and map over a bin RAM.
// ----------------------------------------------------------------------------
// The block works on one request at a time over a single-port-per-side bin RAM
// of DEPTH_BINS entries (10000 by default) with a registered read. Accumulate
// reads its bin when the request is taken and writes it back in S_ACC; map
// waits in S_MAP until the previous result has been taken. Clear writes one
// bin per cycle; the same pass runs after reset, so no request is taken until
// every bin is cleared. Finalize first builds the running sum, reading and
// writing each bin in S_FIN1_RD and S_FIN1_WR, then rescales bins 1 and up
// through S_FIN2_RD, S_FIN2_LOAD and S_FIN2_WAIT, waiting on the bit-serial
// divider for each bin; the rescale is skipped when the histogram is empty.
// Results leave through an output register, so the next request can be taken
// while a map result is still waiting.
module depth_crop_histogram_shader
    import dchs_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480,
    parameter int DEPTH_BINS   = 10000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pixel_req_t        req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pixel_rsp_t        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int AW = $clog2(DEPTH_BINS);
    localparam logic [AW-1:0] LAST_BIN = AW'(DEPTH_BINS - 1);
    localparam logic [12:0] IMG_W_LIM = 13'(IMAGE_WIDTH);
    localparam logic [12:0] IMG_H_LIM = 13'(IMAGE_HEIGHT);
    localparam logic [16:0] BINS_LIM  = 17'(DEPTH_BINS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ACC,
        S_MAP,
        S_FIN1_RD,
        S_FIN1_WR,
        S_FIN2_RD,
        S_FIN2_LOAD,
        S_FIN2_WAIT
    } state_t;

    state_t state_reg;

    logic [9:0]  crop_left_reg;
    logic [9:0]  crop_right_reg;
    logic [8:0]  crop_top_reg;
    logic [8:0]  crop_bottom_reg;
    logic [13:0] near_limit_reg;
    logic [13:0] far_limit_reg;

    logic [AW-1:0]    idx_reg;
    logic [BIN_W-1:0] prev_reg;
    logic [BIN_W-1:0] total_reg;
    logic             keep_reg;
    logic             rsp_valid_reg;
    pixel_rsp_t       rsp_reg;

    logic [BIN_W-1:0] bin_mem [DEPTH_BINS];
    logic [BIN_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [BIN_W-1:0] wr_data;

    // Address of the bin an accumulate request read, held for the write-back.
    logic [AW-1:0]    rd_addr_hold_reg;

    logic              keep;
    logic [BIN_W:0]    sum_wide;
    logic [BIN_W-1:0]  sum_next;
    logic              last_bin;
    logic              cfg_write;
    logic              rsp_load;
    logic              div_start;
    logic [BIN_W-1:0]  div_rest;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crop_left_reg   <= CROP_LEFT_RST;
            crop_right_reg  <= CROP_RIGHT_RST;
            crop_top_reg    <= CROP_TOP_RST;
            crop_bottom_reg <= CROP_BOTTOM_RST;
            near_limit_reg  <= NEAR_LIMIT_RST;
            far_limit_reg   <= FAR_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_CROP_LEFT:   crop_left_reg   <= pwdata[9:0];
                REG_CROP_RIGHT:  crop_right_reg  <= pwdata[9:0];
                REG_CROP_TOP:    crop_top_reg    <= pwdata[8:0];
                REG_CROP_BOTTOM: crop_bottom_reg <= pwdata[8:0];
                REG_NEAR_LIMIT:  near_limit_reg  <= pwdata[13:0];
                REG_FAR_LIMIT:   far_limit_reg   <= pwdata[13:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CROP_LEFT:   prdata = DATA_W'(crop_left_reg);
            REG_CROP_RIGHT:  prdata = DATA_W'(crop_right_reg);
            REG_CROP_TOP:    prdata = DATA_W'(crop_top_reg);
            REG_CROP_BOTTOM: prdata = DATA_W'(crop_bottom_reg);
            REG_NEAR_LIMIT:  prdata = DATA_W'(near_limit_reg);
            REG_FAR_LIMIT:   prdata = DATA_W'(far_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Keep test on the incoming request
    // ------------------------------------------------------------------------
    always_comb
    begin
        keep = (req.column >= crop_left_reg) && (req.column <= crop_right_reg)
            && (req.row >= crop_top_reg) && (req.row <= crop_bottom_reg)
            && (13'(req.column) < IMG_W_LIM) && (13'(req.row) < IMG_H_LIM)
            && (req.depth > 16'(near_limit_reg)) && (req.depth < 16'(far_limit_reg))
            && (17'(req.depth) < BINS_LIM);
    end

    // ------------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------------
    assign sum_wide = {1'b0, rd_data_reg} + {1'b0, prev_reg};
    assign sum_next = sum_wide[BIN_W] ? BIN_MAX : sum_wide[BIN_W-1:0];
    assign last_bin = (idx_reg == LAST_BIN);
    assign div_rest = (rd_data_reg <= total_reg) ? (total_reg - rd_data_reg) : '0;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_load  = (state_reg == S_MAP) && (!rsp_valid_reg || rsp_ready);

    // Memory port control. Requests never overlap, so a bin is always written
    // back before the next read of the same bin is issued.
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = '0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = req.depth[AW-1:0];
                rd_en   = req_valid && keep
                    && ((req.action == ACT_ACCUMULATE) || (req.action == ACT_MAP));
            end
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_ACC:
            begin
                wr_addr = rd_addr_hold_reg;
                wr_en   = keep_reg && (rd_data_reg != BIN_MAX);
                wr_data = rd_data_reg + 1'b1;
            end
            S_MAP:
            begin
            end
            S_FIN1_RD, S_FIN2_RD:
            begin
                rd_en = 1'b1;
            end
            S_FIN1_WR:
            begin
                wr_en   = 1'b1;
                wr_data = sum_next;
            end
            S_FIN2_LOAD:
            begin
                div_start = 1'b1;
            end
            S_FIN2_WAIT:
            begin
                wr_en   = div_done;
                wr_data = BIN_W'(div_quot);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_addr_hold_reg <= rd_addr;
        end
    end

    // ------------------------------------------------------------------------
    // Bin memory
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bin_mem[rd_addr];
        end
    end

    dchs_shade_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .rest  (div_rest),
        .total (total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            keep_reg      <= 1'b0;
            prev_reg      <= '0;
            total_reg     <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        keep_reg <= keep;
                        unique case (req.action)
                            ACT_CLEAR:
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            ACT_ACCUMULATE:
                            begin
                                state_reg <= S_ACC;
                            end
                            ACT_FINALIZE:
                            begin
                                idx_reg   <= '0;
                                prev_reg  <= '0;
                                state_reg <= S_FIN1_RD;
                            end
                            ACT_MAP:
                            begin
                                state_reg <= S_MAP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    if (last_bin)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_ACC:
                begin
                    state_reg <= S_IDLE;
                end
                S_MAP:
                begin
                    if (rsp_load)
                    begin
                        if (keep_reg)
                        begin
                            rsp_reg.primary_channel <= KEPT_LEVEL;
                            rsp_reg.shade           <= rd_data_reg[7:0];
                        end
                        else
                        begin
                            rsp_reg.primary_channel <= '0;
                            rsp_reg.shade           <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_FIN1_RD:
                begin
                    state_reg <= S_FIN1_WR;
                end
                S_FIN1_WR:
                begin
                    prev_reg <= sum_next;
                    if (last_bin)
                    begin
                        total_reg <= sum_next;
                        idx_reg   <= AW'(1);
                        // An empty histogram keeps its all-zero running sums.
                        if (sum_next == '0)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_FIN2_RD;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FIN1_RD;
                    end
                end
                S_FIN2_RD:
                begin
                    state_reg <= S_FIN2_LOAD;
                end
                S_FIN2_LOAD:
                begin
                    state_reg <= S_FIN2_WAIT;
                end
                S_FIN2_WAIT:
                begin
                    if (div_done)
                    begin
                        if (last_bin)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_FIN2_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr <= LAST_BIN))
        else $error("bin write outside the store");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_FIN2_WAIT))
        else $error("divider finished outside the rescale pass");

    a_rescale_nonzero_total: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN2_RD) || (state_reg == S_FIN2_LOAD)
            || (state_reg == S_FIN2_WAIT)) |-> (total_reg != '0))
        else $error("rescale pass entered with an empty histogram");

    a_map_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MAP) && !rsp_valid) |=> rsp_valid)
        else $error("map request did not produce a result with a free slot");

endmodule
